[rtl/dfcm_pkg.sv]
// ----------------------------------------------------------------------------
// dfcm_pkg
// Shared constants, types and the command word matcher for the
// dollar-framed command matcher.
// ----------------------------------------------------------------------------
package dfcm_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int HEAD_LEN  = 5;   // longest command word
  localparam int HEAD_W    = $clog2(HEAD_LEN);

  localparam logic [7:0] END_MARK = 8'h24;

  localparam logic [3:0] CODE_NONE  = 4'd0;
  localparam logic [3:0] CODE_ZAN   = 4'd1;
  localparam logic [3:0] CODE_ONE   = 4'd2;
  localparam logic [3:0] CODE_TWO   = 4'd3;
  localparam logic [3:0] CODE_DISS  = 4'd4;
  localparam logic [3:0] CODE_FOUR  = 4'd5;
  localparam logic [3:0] CODE_FIVE  = 4'd6;
  localparam logic [3:0] CODE_THREE = 4'd7;
  localparam logic [3:0] CODE_HEART = 4'd8;

  // first bytes of the frame, byte 0 in the top byte
  typedef logic [0:HEAD_LEN-1][7:0] head_t;

  typedef struct packed {
    logic wr_byte;    // store an ordinary byte
    logic frame_end;  // '$' taken: latch length and code, clear count
    logic rd;         // read one frame byte into the output register
    logic step;       // advance the echo index
  } cmd_t;

  typedef struct packed {
    logic is_end;     // incoming byte is the end mark
    logic empty;      // frame count is zero
    logic last;       // echo index is at the final byte
  } status_t;

  function automatic logic [3:0] match_code(input logic [IDX_W-1:0] len,
                                            input head_t head);
    logic [3:0] code;
    code = CODE_NONE;
    if (len == IDX_W'(3)) begin
      if (head[0:2] == "zan")      code = CODE_ZAN;
      else if (head[0:2] == "one") code = CODE_ONE;
      else if (head[0:2] == "two") code = CODE_TWO;
    end else if (len == IDX_W'(4)) begin
      if (head[0:3] == "diss")      code = CODE_DISS;
      else if (head[0:3] == "four") code = CODE_FOUR;
      else if (head[0:3] == "five") code = CODE_FIVE;
    end else if (len == IDX_W'(5)) begin
      if (head[0:4] == "three")      code = CODE_THREE;
      else if (head[0:4] == "heart") code = CODE_HEART;
    end
    return code;
  endfunction

endpackage

[rtl/dollar_framed_command_matcher.sv]
// ----------------------------------------------------------------------------
// dollar_framed_command_matcher
// Collects '$'-terminated frames of received bytes, matches them against
// eight command words and echoes each frame with its command code.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall / in_rx_byte. One byte per transfer.
// A byte other than 0x24 is stored and takes one cycle; the block is ready
// again on the next cycle. After 32 stored bytes the count wraps to zero.
// A 0x24 byte ends the frame. An empty frame gives nothing and the block is
// ready on the next cycle; otherwise in_stall stays high while the frame
// is echoed.
// Output channel: out_valid / out_stall / out_echo_byte, out_last_byte,
// out_command_code. One transfer per stored byte, in stored order, with
// out_last_byte on the final one and the same code on every one.
// Each echoed byte passes a read state (a frame store read into the output
// register) and then a send state; the first byte follows the read state
// after the 0x24 transfer, and no new byte is taken until the echo is done.
// A stall simply holds the current byte; the walk resumes when it drops.
// Reset clears the frame count and returns the controller to idle.
// ----------------------------------------------------------------------------
module dollar_framed_command_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_echo_byte,
  output logic       out_last_byte,
  output logic [3:0] out_command_code
);

  dfcm_pkg::cmd_t    cmd;
  dfcm_pkg::status_t status;

  dfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dfcm_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .rx_byte      (in_rx_byte),
    .echo_byte    (out_echo_byte),
    .last_byte    (out_last_byte),
    .command_code (out_command_code)
  );

endmodule

[rtl/dfcm_datapath.sv]
// ----------------------------------------------------------------------------
// dfcm_datapath
// Frame store, frame count, head bytes for matching and the echo
// output register.
// ----------------------------------------------------------------------------
module dfcm_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dfcm_pkg::cmd_t         cmd,
  output dfcm_pkg::status_t      status,
  input  logic [7:0]             rx_byte,
  output logic [7:0]             echo_byte,
  output logic                   last_byte,
  output logic [3:0]             command_code
);

  logic [7:0]                 mem [dfcm_pkg::BUF_DEPTH];
  logic [dfcm_pkg::IDX_W-1:0] count_r, count_nxt;
  logic [dfcm_pkg::IDX_W-1:0] len_r;
  logic [dfcm_pkg::IDX_W-1:0] idx_r, idx_nxt;
  dfcm_pkg::head_t            head_r;
  logic [7:0]                 echo_r;
  logic                       last_r;
  logic [3:0]                 code_r;

  assign status.is_end = (rx_byte == dfcm_pkg::END_MARK);
  assign status.empty  = (count_r == '0);
  assign status.last   = (idx_r == len_r - dfcm_pkg::IDX_W'(1));

  always_comb begin
    count_nxt = count_r;
    if (cmd.frame_end) begin
      count_nxt = '0;
    end else if (cmd.wr_byte) begin
      // count wraps and the frame restarts when the store is full
      if (count_r == dfcm_pkg::IDX_W'(dfcm_pkg::BUF_DEPTH - 1)) begin
        count_nxt = '0;
      end else begin
        count_nxt = count_r + dfcm_pkg::IDX_W'(1);
      end
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.frame_end) begin
      idx_nxt = '0;
    end else if (cmd.step) begin
      idx_nxt = idx_r + dfcm_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.frame_end) begin
      len_r  <= count_r;
      code_r <= dfcm_pkg::match_code(count_r, head_r);
    end
    if (cmd.wr_byte && count_r < dfcm_pkg::IDX_W'(dfcm_pkg::HEAD_LEN)) begin
      head_r[count_r[dfcm_pkg::HEAD_W-1:0]] <= rx_byte;
    end
  end

  // frame store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[count_r] <= rx_byte;
    end
    if (cmd.rd) begin
      echo_r <= mem[idx_r];
      last_r <= status.last;
    end
  end

  assign echo_byte    = echo_r;
  assign last_byte    = last_r;
  assign command_code = code_r;

endmodule

[rtl/dfcm_ctrl.sv]
// ----------------------------------------------------------------------------
// dfcm_ctrl
// Controller: takes bytes while idle, then walks the echo of a frame
// one byte at a time through read and send states.
// ----------------------------------------------------------------------------
module dfcm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  dfcm_pkg::status_t   status,
  output dfcm_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign accept    = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd.wr_byte   = 1'b0;
    cmd.frame_end = 1'b0;
    cmd.rd        = 1'b0;
    cmd.step      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (status.is_end) begin
            cmd.frame_end = 1'b1;
            if (!status.empty) begin
              state_nxt = ST_READ;
            end
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall) begin
          if (status.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/dfcm_checker.sv]
// ----------------------------------------------------------------------------
// dfcm_checker
// Port-level checks for the dollar-framed command matcher.
// ----------------------------------------------------------------------------
module dfcm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_echo_byte,
  input logic       out_last_byte,
  input logic [3:0] out_command_code
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_echo_byte)
      && $stable(out_last_byte) && $stable(out_command_code))
    else $error("stalled output changed");

  // no input transfer while an echo is in progress
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during echo");

  // an ordinary byte never produces a result on the next cycle
  a_plain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_rx_byte != dfcm_pkg::END_MARK
      |=> !out_valid && !in_stall)
    else $error("ordinary byte produced output");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_command_code <= dfcm_pkg::CODE_HEART)
    else $error("command code out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind dollar_framed_command_matcher dfcm_checker u_dfcm_checker (.*);
